// ===== hdl/fca_pkg.sv =====
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types, codes and the CRC-8 step for the framed command agent.
// ----------------------------------------------------------------------------
package fca_pkg;

  localparam int MAX_CHUNK_BYTES_DEF = 127;
  localparam int VD_QUEUE_SLOTS      = 4;

  localparam logic [7:0] HEAD_BYTE = 8'hAA;
  localparam logic [7:0] ACK_HEAD  = 8'hBB;
  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] CMD_RELAY = 8'hA1;
  localparam logic [7:0] CMD_PING  = 8'hB1;
  localparam logic [7:0] ST_OK     = 8'h00;
  localparam logic [7:0] ST_REJECT = 8'h02;
  localparam logic [7:0] ST_FAIL   = 8'hFF;

  localparam logic [2:0] ACK_POS_HEAD   = 3'd0;
  localparam logic [2:0] ACK_POS_SEQ    = 3'd1;
  localparam logic [2:0] ACK_POS_STATUS = 3'd2;
  localparam logic [2:0] ACK_POS_DEPTH  = 3'd3;
  localparam logic [2:0] ACK_POS_CRC    = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
    logic [3:0] queue_fill;
  } in_word_t;

  typedef struct packed {
    logic [7:0] ack_byte;
    logic       ack_final;
    logic [2:0] relay_drive;
  } out_word_t;

  // judged frame handed from front to back
  typedef struct packed {
    logic       keep;
    logic [7:0] seq;
    logic [7:0] status;
    logic [7:0] depth;
    logic       relay_en;
    logic [2:0] relay_mask;
    logic       relay_level;
  } verdict_t;

  function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/fca_front.sv =====
// ----------------------------------------------------------------------------
// fca_front
// Frame parser: takes one byte a cycle unless stalled, runs the CRC and judges the frame.
// ----------------------------------------------------------------------------
module fca_front #(
  parameter int MAX_CHUNK_BYTES = fca_pkg::MAX_CHUNK_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  fca_pkg::in_word_t  req,
  output logic               vd_push,
  output fca_pkg::verdict_t  vd,
  input  logic               q_full
);
  import fca_pkg::*;

  localparam int IDX_W = $clog2(MAX_CHUNK_BYTES + 1);

  logic [IDX_W-1:0] idx, idx_next;
  logic             start_ok, start_ok_next;
  logic [7:0]       seq, seq_next;
  logic [7:0]       cmd, cmd_next;
  logic [7:0]       plen, plen_next;
  logic [7:0]       pin, pin_next;
  logic [7:0]       level, level_next;
  logic [7:0]       crc, crc_next;
  logic             crc_good, crc_good_next;
  logic             take;
  logic [8:0]       crc_pos;
  logic [8:0]       idx9;
  logic             accept;
  logic             hdr_bad;
  logic             arg_bad;

  assign req_stall = q_full;
  assign accept    = req_valid && !q_full;
  assign vd_push   = accept && req.chunk_end;

  always_comb begin
    idx_next      = idx;
    start_ok_next = start_ok;
    seq_next      = seq;
    cmd_next      = cmd;
    plen_next     = plen;
    pin_next      = pin;
    level_next    = level;
    crc_next      = crc;
    crc_good_next = crc_good;
    take          = idx < IDX_W'(MAX_CHUNK_BYTES);
    crc_pos       = 9'd4 + {1'b0, plen};
    idx9          = 9'(idx);
    if (take) begin
      if (idx == '0) begin
        start_ok_next = (req.rx_byte == HEAD_BYTE);
      end else if (idx <= IDX_W'(3)) begin
        if (idx == IDX_W'(1)) begin
          seq_next = req.rx_byte;
        end else if (idx == IDX_W'(2)) begin
          cmd_next = req.rx_byte;
        end else begin
          plen_next = req.rx_byte;
        end
        crc_next = crc8_add(crc, req.rx_byte);
      end else if (idx9 < crc_pos) begin
        if (idx == IDX_W'(4)) pin_next = req.rx_byte;
        if (idx == IDX_W'(5)) level_next = req.rx_byte;
        crc_next = crc8_add(crc, req.rx_byte);
      end else if (idx9 == crc_pos) begin
        crc_good_next = (req.rx_byte == crc);
      end
      idx_next = idx + IDX_W'(1);
    end
  end

  always_comb begin
    hdr_bad        = (idx_next < IDX_W'(4)) || !start_ok_next;
    arg_bad        = (pin_next < 8'd1) || (pin_next > 8'd3) || (level_next > 8'd1);
    vd.keep        = 1'b0;
    vd.seq         = 8'h00;
    vd.status      = ST_FAIL;
    vd.depth       = 8'h00;
    vd.relay_en    = 1'b0;
    vd.relay_mask  = 3'(1) << (pin_next[1:0] - 2'd1);
    vd.relay_level = level_next[0];
    if (!hdr_bad) begin
      vd.seq = seq_next;
      if (crc_good_next) begin
        vd.keep  = 1'b1;
        vd.depth = {4'h0, req.queue_fill};
        if (cmd_next == CMD_RELAY) begin
          vd.status = ST_OK;
          if (plen_next >= 8'd2) begin
            if (arg_bad) begin
              vd.status = ST_REJECT;
            end else begin
              vd.relay_en = 1'b1;
            end
          end
        end else if (cmd_next == CMD_PING) begin
          vd.status = ST_OK;
        end else begin
          vd.status = ST_REJECT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || vd_push) begin
      idx      <= '0;
      start_ok <= 1'b0;
      seq      <= 8'h00;
      cmd      <= 8'h00;
      plen     <= 8'h00;
      pin      <= 8'h00;
      level    <= 8'h00;
      crc      <= 8'h00;
      crc_good <= 1'b0;
    end else if (accept) begin
      idx      <= idx_next;
      start_ok <= start_ok_next;
      seq      <= seq_next;
      cmd      <= cmd_next;
      plen     <= plen_next;
      pin      <= pin_next;
      level    <= level_next;
      crc      <= crc_next;
      crc_good <= crc_good_next;
    end
  end

endmodule

// ===== hdl/fca_queue.sv =====
// ----------------------------------------------------------------------------
// fca_queue
// Small verdict queue between parser and acknowledge sender.
// ----------------------------------------------------------------------------
module fca_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fca_pkg::verdict_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output fca_pkg::verdict_t head
);
  import fca_pkg::*;

  localparam int PTR_W = $clog2(VD_QUEUE_SLOTS);
  localparam int CNT_W = $clog2(VD_QUEUE_SLOTS + 1);

  verdict_t         slots [VD_QUEUE_SLOTS];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(VD_QUEUE_SLOTS));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + PTR_W'(1);
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/fca_back.sv =====
// ----------------------------------------------------------------------------
// fca_back
// Acknowledge sender: applies relay commands, keeps the reply cache and
// sends the five acknowledge bytes.
// ----------------------------------------------------------------------------
module fca_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  fca_pkg::verdict_t  head,
  output logic               pop,
  output logic               ack_valid,
  input  logic               ack_stall,
  output fca_pkg::out_word_t ack
);
  import fca_pkg::*;

  logic       busy;
  logic [2:0] pos;
  logic [7:0] a_seq, a_status, a_depth, a_crc;
  logic       cache_valid;
  logic [7:0] cache_seq, cache_status, cache_depth, cache_crc;
  logic [2:0] relay_levels;
  logic       word_done;
  logic       last_done;
  logic       resend;
  logic [7:0] crc_new;

  assign ack_valid = busy;
  assign word_done = busy && !ack_stall;
  assign last_done = word_done && (pos == ACK_POS_CRC);
  assign pop       = head_valid && (!busy || last_done);
  assign resend    = head.keep && cache_valid && (head.seq == cache_seq);
  assign crc_new   = crc8_add(crc8_add(crc8_add(8'h00, head.seq), head.status), head.depth);

  always_comb begin
    ack.ack_final   = (pos == ACK_POS_CRC);
    ack.relay_drive = relay_levels;
    case (pos)
      ACK_POS_HEAD:   ack.ack_byte = ACK_HEAD;
      ACK_POS_SEQ:    ack.ack_byte = a_seq;
      ACK_POS_STATUS: ack.ack_byte = a_status;
      ACK_POS_DEPTH:  ack.ack_byte = a_depth;
      default:        ack.ack_byte = a_crc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (resend) begin
        a_seq    <= cache_seq;
        a_status <= cache_status;
        a_depth  <= cache_depth;
        a_crc    <= cache_crc;
      end else begin
        a_seq    <= head.seq;
        a_status <= head.status;
        a_depth  <= head.depth;
        a_crc    <= crc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pos          <= ACK_POS_HEAD;
      cache_valid  <= 1'b0;
      cache_seq    <= 8'h00;
      cache_status <= 8'h00;
      cache_depth  <= 8'h00;
      cache_crc    <= 8'h00;
      relay_levels <= 3'b000;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        pos  <= ACK_POS_HEAD;
        if (!resend && head.keep) begin
          cache_valid  <= 1'b1;
          cache_seq    <= head.seq;
          cache_status <= head.status;
          cache_depth  <= head.depth;
          cache_crc    <= crc_new;
          if (head.relay_en) begin
            if (head.relay_level) begin
              relay_levels <= relay_levels | head.relay_mask;
            end else begin
              relay_levels <= relay_levels & ~head.relay_mask;
            end
          end
        end
      end else if (last_done) begin
        busy <= 1'b0;
        pos  <= ACK_POS_HEAD;
      end else if (word_done) begin
        pos <= pos + 3'd1;
      end
    end
  end

endmodule

// ===== hdl/framed_command_agent.sv =====
// ----------------------------------------------------------------------------
// framed_command_agent
// Framed command receiver answering each chunk with a five-byte acknowledge.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle unless req_stall is high. The byte marked
// chunk_end closes the chunk; the frame is judged in that same cycle and its
// verdict goes into a four-entry queue. The sender drains the queue and puts
// out five acknowledge words per chunk, one per cycle while ack_stall is low,
// as the parser takes later chunks. The first word follows the queue and the
// sender registers. req_stall rises only while the verdict queue is full.
// relay_drive shows the relay levels after the frame being acknowledged.
module framed_command_agent #(
  parameter int MAX_CHUNK_BYTES = fca_pkg::MAX_CHUNK_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  fca_pkg::in_word_t  req,
  output logic               ack_valid,
  input  logic               ack_stall,
  output fca_pkg::out_word_t ack
);
  import fca_pkg::*;

  verdict_t vd;
  verdict_t head;
  logic     vd_push;
  logic     q_full;
  logic     head_valid;
  logic     pop;

  fca_front #(
    .MAX_CHUNK_BYTES(MAX_CHUNK_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .vd_push   (vd_push),
    .vd        (vd),
    .q_full    (q_full)
  );

  fca_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (vd_push),
    .push_data  (vd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  fca_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .ack_valid  (ack_valid),
    .ack_stall  (ack_stall),
    .ack        (ack)
  );

endmodule

// ===== hdl/fca_checker.sv =====
// ----------------------------------------------------------------------------
// fca_checker
// Port-level checks on the acknowledge stream of the framed command agent.
// ----------------------------------------------------------------------------
module fca_checker (
  input logic               clk,
  input logic               rst,
  input logic               ack_valid,
  input logic               ack_stall,
  input fca_pkg::out_word_t ack
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    ack_valid && ack_stall |=> ack_valid && $stable(ack))
    else $error("stalled ack word changed");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    ack_valid && !ack_stall && !ack.ack_final |=> ack_valid)
    else $error("gap inside acknowledge");

  a_relay: assert property (@(posedge clk) disable iff (rst)
    ack_valid && !ack.ack_final |=> $stable(ack.relay_drive))
    else $error("relays moved inside acknowledge");

  a_reset: assert property (@(posedge clk)
    rst |=> !ack_valid)
    else $error("ack word right after reset");

endmodule

bind framed_command_agent fca_checker u_fca_checker (
  .clk       (clk),
  .rst       (rst),
  .ack_valid (ack_valid),
  .ack_stall (ack_stall),
  .ack       (ack)
);
